// ===== hdl/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
// No dependencies; every other file in hdl/ imports this package.
package qrs_pkg;

   localparam int COEF_W = 16;
   localparam int ROOT_W = 32;
   localparam int KIND_W = 3;
   localparam int ROOT_FRAC = 16;
   localparam int RAD_SHIFT = 2 * ROOT_FRAC;

   localparam logic [KIND_W-1:0] KIND_ZERO_BOTH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ZERO_ONE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PURE      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DOUBLE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISTINCT  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DEGEN     = 3'd6;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
   } qrs_ctl_type;

endpackage

// ===== hdl/qrs_front.sv =====
// Front end: input register, coefficient products, case decode and radicand.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; #(
   parameter int W = COEF_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic signed [W-1:0]     coef_a,
   input  logic signed [W-1:0]     coef_b,
   input  logic signed [W-1:0]     coef_c,
   output qrs_ctl_type             ctl_o,
   output logic signed [W+16:0]    nb_o,
   output logic signed [W+1:0]     den_o,
   output logic [2*W+33:0]         rad_o
);
   localparam int NW  = W + 17;
   localparam int DNW = W + 2;
   localparam int DW  = 2 * W + 1;

   // stage A: input register
   logic                va_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff;

   // stage B: products
   logic                vb_ff, vb_in;
   logic signed [W-1:0] a2_ff, b2_ff;
   logic [W-1:0]        ma_ff, ma_in;
   logic [2*W-1:0]      bsq_ff, bsq_in, ac_ff, ac_in;
   logic                cz_ff, cz_in, same_ff, same_in;
   logic [W-1:0]        mb_in, mc_in;

   // stage C outputs
   qrs_ctl_type         ctl_ff, ctl_in;
   logic signed [NW-1:0]  nb_ff, nb_in;
   logic signed [DNW-1:0] den_ff, den_in;
   logic [DW-1:0]         rad_ff, rad_in;

   logic [DW:0]           bsq_x, p4, dsum, ddiff;
   logic signed [NW-1:0]  bw;
   logic signed [DNW-1:0] aw;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
      end
      if (advance) begin
         a_ff <= coef_a;
         b_ff <= coef_b;
         c_ff <= coef_c;
      end
   end

   always_comb begin
      ma_in   = a_ff[W-1] ? W'(-a_ff) : W'(a_ff);
      mb_in   = b_ff[W-1] ? W'(-b_ff) : W'(b_ff);
      mc_in   = c_ff[W-1] ? W'(-c_ff) : W'(c_ff);
      bsq_in  = mb_in * mb_in;
      ac_in   = ma_in * mc_in;
      cz_in   = (c_ff == '0);
      same_in = (a_ff[W-1] == c_ff[W-1]);
      vb_in   = va_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= vb_in;
      end
      if (advance) begin
         a2_ff   <= a_ff;
         b2_ff   <= b_ff;
         ma_ff   <= ma_in;
         bsq_ff  <= bsq_in;
         ac_ff   <= ac_in;
         cz_ff   <= cz_in;
         same_ff <= same_in;
      end
   end

   always_comb begin
      bsq_x = {2'b00, bsq_ff};
      p4    = {ac_ff, 2'b00};
      dsum  = bsq_x + p4;
      ddiff = bsq_x - p4;
      bw    = NW'(b2_ff);
      aw    = DNW'(a2_ff);
      nb_in = -(bw <<< ROOT_FRAC);
      den_in = aw <<< 1;
      rad_in = '0;
      ctl_in.valid = vb_ff;
      if (a2_ff == '0) begin
         ctl_in.kind = KIND_DEGEN;
      end else if (b2_ff == '0 && cz_ff) begin
         ctl_in.kind = KIND_ZERO_BOTH;
      end else if (cz_ff) begin
         ctl_in.kind = KIND_ZERO_ONE;
         den_in = aw;
      end else if (b2_ff == '0) begin
         if (same_ff) begin
            ctl_in.kind = KIND_NONE;
         end else begin
            ctl_in.kind = KIND_PURE;
            rad_in = DW'(ac_ff);
            nb_in  = '0;
            den_in = DNW'({1'b0, ma_ff});
         end
      end else if (same_ff && bsq_x < p4) begin
         ctl_in.kind = KIND_NONE;
      end else if (same_ff && bsq_x == p4) begin
         ctl_in.kind = KIND_DOUBLE;
      end else begin
         ctl_in.kind = KIND_DISTINCT;
         rad_in = same_ff ? DW'(ddiff) : DW'(dsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         nb_ff  <= nb_in;
         den_ff <= den_in;
         rad_ff <= rad_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign nb_o  = nb_ff;
   assign den_o = den_ff;
   assign rad_o = {1'b0, rad_ff, {RAD_SHIFT{1'b0}}};

endmodule

// ===== hdl/qrs_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt_cell import qrs_pkg::*; #(
   parameter int SW  = COEF_W + 17,
   parameter int DNW = COEF_W + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  qrs_ctl_type            ctl_i,
   input  logic signed [SW-1:0]   nb_i,
   input  logic signed [DNW-1:0]  den_i,
   input  logic [2*SW-1:0]        rad_i,
   input  logic [SW+1:0]          rem_i,
   input  logic [SW-1:0]          root_i,
   output qrs_ctl_type            ctl_o,
   output logic signed [SW-1:0]   nb_o,
   output logic signed [DNW-1:0]  den_o,
   output logic [2*SW-1:0]        rad_o,
   output logic [SW+1:0]          rem_o,
   output logic [SW-1:0]          root_o
);
   qrs_ctl_type           ctl_ff;
   logic signed [SW-1:0]  nb_ff;
   logic signed [DNW-1:0] den_ff;
   logic [2*SW-1:0]       rad_ff, rad_in;
   logic [SW+1:0]         rem_ff, rem_in;
   logic [SW-1:0]         root_ff, root_in;
   logic [SW+1:0]         t, trial;
   logic                  take;

   always_comb begin
      t       = {rem_i[SW-1:0], rad_i[2*SW-1 -: 2]};
      trial   = {root_i, 2'b01};
      take    = (t >= trial);
      rem_in  = take ? t - trial : t;
      root_in = {root_i[SW-2:0], take};
      rad_in  = {rad_i[2*SW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         nb_ff   <= nb_i;
         den_ff  <= den_i;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign nb_o   = nb_ff;
   assign den_o  = den_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ===== hdl/qrs_prep.sv =====
// Forms both numerators from -b and the root, splits sign and magnitude.
// Depends on qrs_pkg.
module qrs_prep import qrs_pkg::*; #(
   parameter int SW  = COEF_W + 17,
   parameter int DNW = COEF_W + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  qrs_ctl_type            ctl_i,
   input  logic signed [SW-1:0]   nb_i,
   input  logic signed [DNW-1:0]  den_i,
   input  logic [SW-1:0]          root_i,
   output qrs_ctl_type            ctl_o,
   output logic                   neg1_o,
   output logic                   neg2_o,
   output logic [SW:0]            num1_o,
   output logic [SW:0]            num2_o,
   output logic [DNW-2:0]         dmag_o
);
   localparam int NUMW = SW + 2;

   qrs_ctl_type           ctl_ff;
   logic                  neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [SW:0]           num1_ff, num1_in, num2_ff, num2_in;
   logic [DNW-2:0]        dmag_ff, dmag_in;
   logic signed [NUMW-1:0] n1, n2, nbx, sx;

   always_comb begin
      nbx = NUMW'(nb_i);
      sx  = NUMW'({2'b00, root_i});
      n1  = nbx + sx;
      n2  = nbx - sx;
      num1_in = n1[NUMW-1] ? (SW+1)'(-n1) : (SW+1)'(n1);
      num2_in = n2[NUMW-1] ? (SW+1)'(-n2) : (SW+1)'(n2);
      dmag_in = den_i[DNW-1] ? (DNW-1)'(-den_i) : (DNW-1)'(den_i);
      neg1_in = n1[NUMW-1] ^ den_i[DNW-1];
      neg2_in = n2[NUMW-1] ^ den_i[DNW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         neg1_ff <= neg1_in;
         neg2_ff <= neg2_in;
         num1_ff <= num1_in;
         num2_ff <= num2_in;
         dmag_ff <= dmag_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign neg1_o = neg1_ff;
   assign neg2_o = neg2_ff;
   assign num1_o = num1_ff;
   assign num2_o = num2_ff;
   assign dmag_o = dmag_ff;

endmodule

// ===== hdl/qrs_div_cell.sv =====
// One cell of the divider chain: one quotient bit per stage for both roots.
// Depends on qrs_pkg.
module qrs_div_cell import qrs_pkg::*; #(
   parameter int QW  = COEF_W + 18,
   parameter int DMW = COEF_W + 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  qrs_ctl_type     ctl_i,
   input  logic            neg1_i,
   input  logic            neg2_i,
   input  logic [DMW-1:0]  dmag_i,
   input  logic [QW-1:0]   num1_i,
   input  logic [QW-1:0]   num2_i,
   input  logic [DMW-1:0]  rem1_i,
   input  logic [DMW-1:0]  rem2_i,
   input  logic [QW-1:0]   quo1_i,
   input  logic [QW-1:0]   quo2_i,
   output qrs_ctl_type     ctl_o,
   output logic            neg1_o,
   output logic            neg2_o,
   output logic [DMW-1:0]  dmag_o,
   output logic [QW-1:0]   num1_o,
   output logic [QW-1:0]   num2_o,
   output logic [DMW-1:0]  rem1_o,
   output logic [DMW-1:0]  rem2_o,
   output logic [QW-1:0]   quo1_o,
   output logic [QW-1:0]   quo2_o
);
   qrs_ctl_type     ctl_ff;
   logic            neg1_ff, neg2_ff;
   logic [DMW-1:0]  dmag_ff;
   logic [QW-1:0]   num1_ff, num1_in, num2_ff, num2_in;
   logic [DMW-1:0]  rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [QW-1:0]   quo1_ff, quo1_in, quo2_ff, quo2_in;
   logic [DMW:0]    t1, t2, dx;
   logic            ge1, ge2;

   always_comb begin
      dx  = {1'b0, dmag_i};
      t1  = {rem1_i, num1_i[QW-1]};
      t2  = {rem2_i, num2_i[QW-1]};
      ge1 = (t1 >= dx);
      ge2 = (t2 >= dx);
      rem1_in = ge1 ? DMW'(t1 - dx) : DMW'(t1);
      rem2_in = ge2 ? DMW'(t2 - dx) : DMW'(t2);
      quo1_in = {quo1_i[QW-2:0], ge1};
      quo2_in = {quo2_i[QW-2:0], ge2};
      num1_in = {num1_i[QW-2:0], 1'b0};
      num2_in = {num2_i[QW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         neg1_ff <= neg1_i;
         neg2_ff <= neg2_i;
         dmag_ff <= dmag_i;
         num1_ff <= num1_in;
         num2_ff <= num2_in;
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         quo1_ff <= quo1_in;
         quo2_ff <= quo2_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign neg1_o = neg1_ff;
   assign neg2_o = neg2_ff;
   assign dmag_o = dmag_ff;
   assign num1_o = num1_ff;
   assign num2_o = num2_ff;
   assign rem1_o = rem1_ff;
   assign rem2_o = rem2_ff;
   assign quo1_o = quo1_ff;
   assign quo2_o = quo2_ff;

endmodule

// ===== hdl/qrs_back.sv =====
// Output stage: restores signs, clips to Q16.16, masks roots by case.
// Depends on qrs_pkg.
module qrs_back import qrs_pkg::*; #(
   parameter int QW = COEF_W + 18
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  qrs_ctl_type              ctl_i,
   input  logic                     neg1_i,
   input  logic                     neg2_i,
   input  logic [QW-1:0]            quo1_i,
   input  logic [QW-1:0]            quo2_i,
   output logic                     valid_o,
   output logic signed [ROOT_W-1:0] root_first_o,
   output logic signed [ROOT_W-1:0] root_second_o,
   output logic [KIND_W-1:0]        kind_o,
   output logic                     saturated_o
);
   localparam int EW = (QW + 2 > ROOT_W + 2) ? QW + 2 : ROOT_W + 2;
   localparam logic [EW-1:0] POS_MAX = EW'(64'h7FFF_FFFF);
   localparam logic [EW-1:0] NEG_MAX = EW'(64'h8000_0000);

   logic                     valid_ff;
   logic signed [ROOT_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [KIND_W-1:0]        kind_ff;
   logic                     sat_ff, sat_in;
   logic [EW-1:0]            e1, e2;
   logic signed [ROOT_W-1:0] c1, c2;
   logic                     s1, s2, use1, use2;

   always_comb begin
      e1 = EW'(quo1_i);
      e2 = EW'(quo2_i);
      s1 = neg1_i ? (e1 > NEG_MAX) : (e1 > POS_MAX);
      s2 = neg2_i ? (e2 > NEG_MAX) : (e2 > POS_MAX);
      if (neg1_i) begin
         c1 = s1 ? ROOT_W'(NEG_MAX) : ROOT_W'(-e1);
      end else begin
         c1 = s1 ? ROOT_W'(POS_MAX) : ROOT_W'(e1);
      end
      if (neg2_i) begin
         c2 = s2 ? ROOT_W'(NEG_MAX) : ROOT_W'(-e2);
      end else begin
         c2 = s2 ? ROOT_W'(POS_MAX) : ROOT_W'(e2);
      end
      use1 = (ctl_i.kind == KIND_PURE) || (ctl_i.kind == KIND_DOUBLE) ||
             (ctl_i.kind == KIND_DISTINCT);
      use2 = use1 || (ctl_i.kind == KIND_ZERO_ONE);
      r1_in  = use1 ? c1 : '0;
      r2_in  = use2 ? c2 : '0;
      sat_in = (use1 && s1) || (use2 && s2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_i.valid;
      end
      if (advance) begin
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         kind_ff <= ctl_i.kind;
         sat_ff  <= sat_in;
      end
   end

   assign valid_o       = valid_ff;
   assign root_first_o  = r1_ff;
   assign root_second_o = r2_ff;
   assign kind_o        = kind_ff;
   assign saturated_o   = sat_ff;

endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// Channel  | Ports                                              | Direction
// req      | req_valid, req_stall, req_coef_a/b/c              | in
// rsp      | rsp_valid, rsp_stall, rsp_root_first/second,      | out
//          | rsp_case_kind, rsp_saturated                      |
// One transfer per cycle in each direction while rsp_stall does not hold the pipeline.
// The pipeline has three front stages, COEF_WIDTH+17 square root cells, one
// numerator stage, COEF_WIDTH+18 divider cells and one output stage.
// The whole pipeline holds while a result waits under rsp_stall; req_stall
// follows that hold. Synchronous reset clears all valid flags.
module quadratic_root_solver_unit import qrs_pkg::*; #(
   parameter int COEF_WIDTH = COEF_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ROOT_W-1:0]     rsp_root_first,
   output logic signed [ROOT_W-1:0]     rsp_root_second,
   output logic [KIND_W-1:0]            rsp_case_kind,
   output logic                         rsp_saturated
);
   localparam int W   = COEF_WIDTH;
   localparam int SW  = W + 17;
   localparam int DNW = W + 2;
   localparam int QW  = SW + 1;
   localparam int DMW = DNW - 1;

   logic advance;

   qrs_ctl_type           s_ctl  [0:SW];
   logic signed [SW-1:0]  s_nb   [0:SW];
   logic signed [DNW-1:0] s_den  [0:SW];
   logic [2*SW-1:0]       s_rad  [0:SW];
   logic [SW+1:0]         s_rem  [0:SW];
   logic [SW-1:0]         s_root [0:SW];

   qrs_ctl_type     d_ctl  [0:QW];
   logic            d_neg1 [0:QW];
   logic            d_neg2 [0:QW];
   logic [DMW-1:0]  d_dmag [0:QW];
   logic [QW-1:0]   d_num1 [0:QW];
   logic [QW-1:0]   d_num2 [0:QW];
   logic [DMW-1:0]  d_rem1 [0:QW];
   logic [DMW-1:0]  d_rem2 [0:QW];
   logic [QW-1:0]   d_quo1 [0:QW];
   logic [QW-1:0]   d_quo2 [0:QW];

   // hold everything while the output transfer is stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   qrs_front #(.W(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .coef_a   (req_coef_a),
      .coef_b   (req_coef_b),
      .coef_c   (req_coef_c),
      .ctl_o    (s_ctl[0]),
      .nb_o     (s_nb[0]),
      .den_o    (s_den[0]),
      .rad_o    (s_rad[0])
   );

   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SW(SW), .DNW(DNW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (s_ctl[i]),
         .nb_i    (s_nb[i]),
         .den_i   (s_den[i]),
         .rad_i   (s_rad[i]),
         .rem_i   (s_rem[i]),
         .root_i  (s_root[i]),
         .ctl_o   (s_ctl[i+1]),
         .nb_o    (s_nb[i+1]),
         .den_o   (s_den[i+1]),
         .rad_o   (s_rad[i+1]),
         .rem_o   (s_rem[i+1]),
         .root_o  (s_root[i+1])
      );
   end

   qrs_prep #(.SW(SW), .DNW(DNW)) u_prep (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl_i   (s_ctl[SW]),
      .nb_i    (s_nb[SW]),
      .den_i   (s_den[SW]),
      .root_i  (s_root[SW]),
      .ctl_o   (d_ctl[0]),
      .neg1_o  (d_neg1[0]),
      .neg2_o  (d_neg2[0]),
      .num1_o  (d_num1[0]),
      .num2_o  (d_num2[0]),
      .dmag_o  (d_dmag[0])
   );

   assign d_rem1[0] = '0;
   assign d_rem2[0] = '0;
   assign d_quo1[0] = '0;
   assign d_quo2[0] = '0;

   for (genvar j = 0; j < QW; j++) begin : g_div
      qrs_div_cell #(.QW(QW), .DMW(DMW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (d_ctl[j]),
         .neg1_i  (d_neg1[j]),
         .neg2_i  (d_neg2[j]),
         .dmag_i  (d_dmag[j]),
         .num1_i  (d_num1[j]),
         .num2_i  (d_num2[j]),
         .rem1_i  (d_rem1[j]),
         .rem2_i  (d_rem2[j]),
         .quo1_i  (d_quo1[j]),
         .quo2_i  (d_quo2[j]),
         .ctl_o   (d_ctl[j+1]),
         .neg1_o  (d_neg1[j+1]),
         .neg2_o  (d_neg2[j+1]),
         .dmag_o  (d_dmag[j+1]),
         .num1_o  (d_num1[j+1]),
         .num2_o  (d_num2[j+1]),
         .rem1_o  (d_rem1[j+1]),
         .rem2_o  (d_rem2[j+1]),
         .quo1_o  (d_quo1[j+1]),
         .quo2_o  (d_quo2[j+1])
      );
   end

   qrs_back #(.QW(QW)) u_back (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ctl_i         (d_ctl[QW]),
      .neg1_i        (d_neg1[QW]),
      .neg2_i        (d_neg2[QW]),
      .quo1_i        (d_quo1[QW]),
      .quo2_i        (d_quo2[QW]),
      .valid_o       (rsp_valid),
      .root_first_o  (rsp_root_first),
      .root_second_o (rsp_root_second),
      .kind_o        (rsp_case_kind),
      .saturated_o   (rsp_saturated)
   );

endmodule

// ===== verif/qrs_checker.sv =====
// Checker for quadratic_root_solver_unit: predicts each accepted coefficient set
// and compares every result transfer, in order, field by field. Uses qrs_pkg.
module qrs_checker import qrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [COEF_W-1:0] req_coef_a,
   input  logic signed [COEF_W-1:0] req_coef_b,
   input  logic signed [COEF_W-1:0] req_coef_c,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [ROOT_W-1:0] rsp_root_first,
   input  logic signed [ROOT_W-1:0] rsp_root_second,
   input  logic [KIND_W-1:0]        rsp_case_kind,
   input  logic                     rsp_saturated,
   output int                       fail_count,
   output int                       roots_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [ROOT_W-1:0] first;
      logic signed [ROOT_W-1:0] second;
      logic [KIND_W-1:0]        kind;
      logic                     sat;
   } roots_type;

   roots_type expected_roots[$];

   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  cand;
      logic [127:0] sq;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= x) r = cand;
      end
      return r;
   endfunction

   function automatic logic signed [ROOT_W-1:0] clip_root(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic roots_type solve_quadratic(input logic signed [COEF_W-1:0] ca,
                                                 input logic signed [COEF_W-1:0] cb,
                                                 input logic signed [COEF_W-1:0] cc);
      longint       a, b, c, r1, r2, disc, nb, den, s;
      logic [127:0] rad;
      roots_type    res;
      logic         sat;
      a = ca;
      b = cb;
      c = cc;
      r1 = 0;
      r2 = 0;
      sat = 1'b0;
      if (a == 0) begin
         res.kind = KIND_DEGEN;
      end else if (b == 0 && c == 0) begin
         res.kind = KIND_ZERO_BOTH;
      end else if (c == 0) begin
         res.kind = KIND_ZERO_ONE;
         r2 = (-b * 65536) / a;
      end else if (b == 0) begin
         if ((a > 0) == (c > 0)) begin
            res.kind = KIND_NONE;
         end else begin
            // |c| << 32 / |a| stays within 48 bits
            rad = {64'd0, ((c < 0 ? -c : c) << 32) / (a < 0 ? -a : a)};
            res.kind = KIND_PURE;
            r1 = longint'(floor_sqrt(rad));
            r2 = -r1;
         end
      end else begin
         disc = b * b - 4 * a * c;
         nb = -b * 65536;
         den = 2 * a;
         if (disc < 0) begin
            res.kind = KIND_NONE;
         end else if (disc == 0) begin
            res.kind = KIND_DOUBLE;
            r1 = nb / den;
            r2 = r1;
         end else begin
            rad = {64'd0, disc} << 32;
            s = longint'(floor_sqrt(rad));
            res.kind = KIND_DISTINCT;
            r1 = (nb + s) / den;
            r2 = (nb - s) / den;
         end
      end
      res.first = clip_root(r1, sat);
      res.second = clip_root(r2, sat);
      res.sat = sat;
      return res;
   endfunction

   assign roots_pending = expected_roots.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      roots_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_roots.push_back(solve_quadratic(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid && !rsp_stall) begin
            if (expected_roots.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transfer first=%0d second=%0d kind=%0d sat=%0d",
                        $time, rsp_root_first, rsp_root_second, rsp_case_kind, rsp_saturated);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root_first !== want.first) begin
                  fail_count++;
                  $display("%0t: root_first expected %0d actual %0d",
                           $time, want.first, rsp_root_first);
               end
               if (rsp_root_second !== want.second) begin
                  fail_count++;
                  $display("%0t: root_second expected %0d actual %0d",
                           $time, want.second, rsp_root_second);
               end
               if (rsp_case_kind !== want.kind) begin
                  fail_count++;
                  $display("%0t: case_kind expected %0d actual %0d",
                           $time, want.kind, rsp_case_kind);
               end
               if (rsp_saturated !== want.sat) begin
                  fail_count++;
                  $display("%0t: saturated expected %0d actual %0d",
                           $time, want.sat, rsp_saturated);
               end
            end
         end
      end
   end
endmodule

// ===== verif/tb.sv =====
// Top of the quadratic root solver testbench: clock, reset, coefficient stimulus
// and result stall pattern. Needs qrs_pkg, quadratic_root_solver_unit, qrs_checker.
module tb import qrs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 2 * COEF_W + 40;
   localparam int CYCLE_LIMIT = 300000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [COEF_W-1:0] req_coef_a;
   logic signed [COEF_W-1:0] req_coef_b;
   logic signed [COEF_W-1:0] req_coef_c;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [ROOT_W-1:0] rsp_root_first;
   logic signed [ROOT_W-1:0] rsp_root_second;
   logic [KIND_W-1:0]        rsp_case_kind;
   logic                     rsp_saturated;
   int                       fail_count;
   int                       roots_pending;
   int                       cycles;

   quadratic_root_solver_unit dut (.*);

   qrs_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 7))
         0:       return '0;
         1, 2:    return $signed(COEF_W'($urandom_range(0, 64))) - 16'sd32;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   // hold the offer until it is taken, then idle for a random gap, which may be empty
   task automatic send_coefs(input logic signed [COEF_W-1:0] a,
                             input logic signed [COEF_W-1:0] b,
                             input logic signed [COEF_W-1:0] c);
      int gap;
      req_valid  <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: one long hold-off early to fill the pipeline, then random stalls
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      repeat (30) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (400) @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         repeat (pick_gap() + 1) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin
      logic signed [COEF_W-1:0] a, b, c;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_coefs(16'sd0, 16'sd256, 16'sd512);          // degenerate
      send_coefs(16'sd0, -16'sd32768, 16'sd32767);
      send_coefs(16'sd256, 16'sd0, 16'sd0);            // both zero
      send_coefs(-16'sd32768, 16'sd0, 16'sd0);
      send_coefs(16'sd256, 16'sd512, 16'sd0);          // one zero root
      send_coefs(16'sd1, -16'sd32768, 16'sd0);         // saturates high
      send_coefs(-16'sd1, -16'sd32768, 16'sd0);        // most negative root, not saturated
      send_coefs(-16'sd32768, 16'sd32767, 16'sd0);
      send_coefs(16'sd256, 16'sd0, -16'sd1024);        // pure pair
      send_coefs(-16'sd256, 16'sd0, 16'sd1024);
      send_coefs(16'sd1, 16'sd0, -16'sd32768);         // large pure pair
      send_coefs(16'sd256, 16'sd0, 16'sd1024);         // pure, no real
      send_coefs(16'sd256, 16'sd256, 16'sd1024);       // negative discriminant
      send_coefs(16'sd256, 16'sd512, 16'sd256);        // coincident
      send_coefs(-16'sd1, 16'sd2, -16'sd1);
      send_coefs(16'sd256, -16'sd768, 16'sd512);       // distinct
      send_coefs(16'sd1, -16'sd32768, -16'sd32768);    // distinct, saturates
      send_coefs(-16'sd32768, -16'sd32768, 16'sd32767);
      send_coefs(16'sd32767, 16'sd32767, -16'sd32768);
      send_coefs(-16'sd1, 16'sd32767, 16'sd32767);

      for (int i = 0; i < 500; i++) begin
         a = rand_coef();
         b = rand_coef();
         c = rand_coef();
         send_coefs(a, b, c);
      end
      req_valid <= 1'b0;

      wait (roots_pending == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_prep.sv
hdl/qrs_div_cell.sv
hdl/qrs_back.sv
hdl/quadratic_root_solver_unit.sv
verif/qrs_checker.sv
verif/tb.sv
